@@ rtl/ths_pkg.sv @@
// ============================================================================
// ths_pkg: triaxial hexatorus point package
// Payload types, fixed-point constants and the stage records shared by the
// sine cells and the divider cells.
// ============================================================================
package ths_pkg;

    // Pi in Q2.30 radians, one in Q1.30, sqrt(2) in Q1.15.
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;
    localparam logic [17:0] SQRT2_Q15 = 18'd46341;

    // Divisors of the Horner steps of the odd sine polynomial, in order.
    localparam int unsigned POLY_DIV [4] = '{72, 42, 20, 6};

    // Quotient bits produced by the divider chain; anything wider saturates.
    localparam int unsigned QUO_BITS = 25;
    localparam int unsigned DEN_BITS = 18;

    localparam logic [23:0] OUT_MAX = 24'h7FFFFF;
    localparam logic [23:0] OUT_MIN = 24'h800000;

    typedef struct packed {
        logic signed [15:0] angle_u;
        logic signed [15:0] angle_v;
    } t_in;

    typedef struct packed {
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
    } t_out;

    // One Horner step of the sine polynomial.
    typedef struct packed {
        logic        neg;
        logic [30:0] x;
        logic [31:0] x2;
        logic [30:0] t;
    } t_poly;

    // One restoring division step.
    typedef struct packed {
        logic                neg;
        logic                ovf;
        logic [DEN_BITS-1:0] rem;
        logic [DEN_BITS-1:0] den2;
        logic [QUO_BITS-1:0] num_lo;
        logic [QUO_BITS-1:0] quo;
    } t_div;

endpackage

@@ rtl/ths_poly_cell.sv @@
// ============================================================================
// ths_poly_cell: one Horner step of the sine polynomial
// Computes t' = 1 - ((x2 * t) >> 30) / DIV over three register stages.
// ============================================================================
module ths_poly_cell #(
    parameter int unsigned DIV = 6
) (
    input  logic          i_clk,
    input  ths_pkg::t_poly i_cell,
    output ths_pkg::t_poly o_cell
);

    localparam logic [63:0] RECIP64 = (64'd1 << 32) / DIV;
    localparam logic [31:0] RECIP   = RECIP64[31:0];

    ths_pkg::t_poly r_a, r_b, r_c;
    logic [31:0]    r_pa, r_pb, r_qb;

    logic [62:0] prod_a;
    logic [63:0] prod_b;
    logic [31:0] rem;
    logic [31:0] quo;

    always_comb begin
        prod_a = 63'(i_cell.x2) * 63'(i_cell.t);
        prod_b = 64'(r_pa) * 64'(RECIP);
        // The reciprocal estimate is low by at most one.
        rem    = r_pb - 32'(r_qb * 32'(DIV));
        quo    = r_qb + 32'(rem >= 32'(DIV));
    end

    always_ff @(posedge i_clk) begin
        r_a  <= i_cell;
        r_pa <= prod_a[61:30];
        r_b  <= r_a;
        r_pb <= r_pa;
        r_qb <= prod_b[63:32];
        r_c.neg <= r_b.neg;
        r_c.x   <= r_b.x;
        r_c.x2  <= r_b.x2;
        r_c.t   <= ths_pkg::ONE_Q30 - quo[30:0];
    end

    assign o_cell = r_c;

endmodule

@@ rtl/ths_sine.sv @@
// ============================================================================
// ths_sine: pipelined Q1.15 sine of a binary angle
// Quadrant fold, scaling to radians, then a chain of four Horner cells.
// One angle per cycle.
// ============================================================================
module ths_sine #(
    parameter int unsigned ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic signed [15:0]    o_sin
);

    localparam int unsigned AB = ANGLE_BITS;
    localparam logic [AB-1:0] HALF    = AB'(1) << (AB - 1);
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    logic          r_neg0, r_neg1;
    logic [AB-2:0] r_fold;
    logic [30:0]   r_x;
    ths_pkg::t_poly r_head;
    ths_pkg::t_poly w_chain [5];
    logic [31:0]   r_s;
    logic          r_sneg;
    logic signed [15:0] r_out;

    logic [AB-1:0]  fold_in;
    logic [AB-1:0]  fold;
    logic [AB+31:0] xprod;
    logic [61:0]    x2prod;
    logic [61:0]    sprod;
    logic [32:0]    rnd;
    logic [15:0]    mag;

    always_comb begin
        fold_in = {1'b0, i_angle[AB-2:0]};
        fold    = (fold_in > QUARTER) ? HALF - fold_in : fold_in;
        xprod   = (AB+32)'(r_fold) * (AB+32)'(ths_pkg::PI_Q30)
                + ((AB+32)'(1) << (AB - 2));
        x2prod  = 62'(r_x) * 62'(r_x);
        sprod   = 62'(w_chain[4].x) * 62'(w_chain[4].t);
        rnd     = 33'(r_s) + 33'(16384);
        mag     = (rnd[32:15] > 18'd32767) ? 16'd32767 : rnd[30:15];
    end

    always_ff @(posedge i_clk) begin
        r_fold      <= fold[AB-2:0];
        r_neg0      <= i_angle[AB-1];
        r_x         <= xprod[AB+29:AB-1];
        r_neg1      <= r_neg0;
        r_head.neg  <= r_neg1;
        r_head.x    <= r_x;
        r_head.x2   <= x2prod[61:30];
        r_head.t    <= ths_pkg::ONE_Q30;
        r_s         <= sprod[61:30];
        r_sneg      <= w_chain[4].neg;
        r_out       <= r_sneg ? -$signed(mag) : $signed(mag);
    end

    assign w_chain[0] = r_head;

    for (genvar k = 0; k < 4; k++) begin : g_cell
        ths_poly_cell #(
            .DIV (ths_pkg::POLY_DIV[k])
        ) u_cell (
            .i_clk  (i_clk),
            .i_cell (w_chain[k]),
            .o_cell (w_chain[k+1])
        );
    end

    assign o_sin = r_out;

endmodule

@@ rtl/ths_div_cell.sv @@
// ============================================================================
// ths_div_cell: one restoring division step
// Shifts in the next numerator bit, subtracts the divisor when it fits and
// appends one quotient bit.
// ============================================================================
module ths_div_cell (
    input  logic          i_clk,
    input  ths_pkg::t_div i_cell,
    output ths_pkg::t_div o_cell
);

    localparam int unsigned DB = ths_pkg::DEN_BITS;
    localparam int unsigned QB = ths_pkg::QUO_BITS;

    ths_pkg::t_div r_cell;
    logic [DB:0]   trial;
    logic          fits;

    always_comb begin
        trial = {i_cell.rem, i_cell.num_lo[QB-1]};
        fits  = trial >= (DB+1)'(i_cell.den2);
    end

    always_ff @(posedge i_clk) begin
        r_cell.neg    <= i_cell.neg;
        r_cell.ovf    <= i_cell.ovf;
        r_cell.den2   <= i_cell.den2;
        r_cell.rem    <= fits ? DB'(trial - (DB+1)'(i_cell.den2)) : trial[DB-1:0];
        r_cell.num_lo <= {i_cell.num_lo[QB-2:0], 1'b0};
        r_cell.quo    <= {i_cell.quo[QB-2:0], fits};
    end

    assign o_cell = r_cell;

endmodule

@@ rtl/ths_coord.sv @@
// ============================================================================
// ths_coord: one coordinate from a sine and a cosine
// radius * sine over (sqrt2 + cosine), rounded to nearest and saturated,
// through a chain of restoring division cells.
// ============================================================================
module ths_coord #(
    parameter int unsigned OUT_FRAC_BITS = 12
) (
    input  logic               i_clk,
    input  logic [15:0]        i_radius,
    input  logic signed [15:0] i_sin,
    input  logic signed [15:0] i_cos,
    output logic signed [23:0] o_coord
);

    localparam int unsigned QB = ths_pkg::QUO_BITS;
    localparam int unsigned DB = ths_pkg::DEN_BITS;
    localparam int unsigned NW = OUT_FRAC_BITS + 25;

    logic [30:0]   r_mag;
    logic          r_neg;
    logic [16:0]   r_den;
    ths_pkg::t_div r_head;
    ths_pkg::t_div w_chain [QB+1];
    logic signed [23:0] r_out;

    logic signed [32:0] prod;
    logic [32:0]        prod_mag;
    logic signed [17:0] dsum;
    logic [NW-1:0]      num;
    logic [NW-1:0]      num_hi;
    logic [DB-1:0]      den2;
    logic [QB-1:0]      quo;

    always_comb begin
        prod     = $signed({1'b0, i_radius}) * 33'(i_sin);
        prod_mag = prod[32] ? 33'(-prod) : 33'(prod);
        dsum     = $signed(ths_pkg::SQRT2_Q15) + 18'(i_cos);
        // Rounded quotient (2*mag + den) / (2*den).
        num      = (NW'(r_mag) << (OUT_FRAC_BITS - 7)) + NW'(r_den);
        num_hi   = num >> QB;
        den2     = {r_den, 1'b0};
        quo      = w_chain[QB].quo;
    end

    always_ff @(posedge i_clk) begin
        r_mag          <= prod_mag[30:0];
        r_neg          <= prod[32];
        r_den          <= dsum[16:0];
        r_head.neg     <= r_neg;
        r_head.ovf     <= num_hi >= NW'(den2);
        r_head.rem     <= num_hi[DB-1:0];
        r_head.den2    <= den2;
        r_head.num_lo  <= num[QB-1:0];
        r_head.quo     <= '0;
        if (w_chain[QB].neg) begin
            if (w_chain[QB].ovf || quo > (QB'(1) << 23)) begin
                r_out <= ths_pkg::OUT_MIN;
            end else begin
                r_out <= -$signed(quo[23:0]);
            end
        end else begin
            if (w_chain[QB].ovf || quo > QB'(ths_pkg::OUT_MAX)) begin
                r_out <= ths_pkg::OUT_MAX;
            end else begin
                r_out <= $signed(quo[23:0]);
            end
        end
    end

    assign w_chain[0] = r_head;

    for (genvar k = 0; k < QB; k++) begin : g_cell
        ths_div_cell u_cell (
            .i_clk  (i_clk),
            .i_cell (w_chain[k]),
            .o_cell (w_chain[k+1])
        );
    end

    assign o_coord = r_out;

endmodule

@@ rtl/triaxial_hexatorus_point.sv @@
// ============================================================================
// triaxial_hexatorus_point: one point of a triaxial hexatorus surface
// Evaluates x, y and z in signed Q12.12 for a pair of binary angles.
// ============================================================================
// Usage:
//   Drive i_in with angle_u and angle_v and raise start for one cycle; a
//   transfer takes place at every edge with start high and busy low. busy
//   stays low, so a new angle pair may be given in every cycle.
//   Each point appears on o_out for exactly one cycle with o_strobe high;
//   one point leaves per cycle at full rate.
//   A point passes one input register, the sine pipeline (fold, scaling
//   and four Horner cells) and the 25-cell restoring divider chain of each
//   coordinate.
//   Write the radius register (i_cfg_valid / o_cfg_ready, always ready)
//   only while no point is in flight; the block does not enforce it.
//   A synchronous reset sets the radius to 1.0 and drops all pending
//   strobes. The receiver has no way to stall results; it takes each one
//   in the cycle it is shown.
// ============================================================================
module triaxial_hexatorus_point #(
    parameter int unsigned ANGLE_BITS    = 16,
    parameter int unsigned OUT_FRAC_BITS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  ths_pkg::t_in i_in,
    output logic         o_strobe,
    output ths_pkg::t_out o_out,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data
);

    localparam int unsigned AB = ANGLE_BITS;
    localparam int unsigned LATENCY = 46;
    localparam logic [AB:0]   TURN    = (AB+1)'(1) << AB;
    localparam logic [AB:0]   THIRD1  = (TURN + (AB+1)'(1)) / 3;
    localparam logic [AB-1:0] THIRD   = THIRD1[AB-1:0];
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    logic [15:0]         r_radius;
    logic [LATENCY-1:0]  r_vld;
    logic [AB-1:0]       r_ang [6];

    logic signed [AB+15:0] ext_u, ext_v;
    logic [AB-1:0]         u, v;
    logic signed [15:0]    w_sin [6];

    always_comb begin
        ext_u = (AB+16)'(i_in.angle_u);
        ext_v = (AB+16)'(i_in.angle_v);
        u     = ext_u[AB-1:0];
        v     = ext_v[AB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd256;
            r_vld    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
            r_vld <= {r_vld[LATENCY-2:0], start};
        end
    end

    // Sine arguments; cosines are taken as sines a quarter turn ahead.
    always_ff @(posedge i_clk) begin
        r_ang[0] <= u;
        r_ang[1] <= v + QUARTER;
        r_ang[2] <= u + THIRD;
        r_ang[3] <= v + THIRD + QUARTER;
        r_ang[4] <= u - THIRD + QUARTER;
        r_ang[5] <= v - THIRD + QUARTER;
    end

    for (genvar k = 0; k < 6; k++) begin : g_sine
        ths_sine #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_sine (
            .i_clk   (i_clk),
            .i_angle (r_ang[k]),
            .o_sin   (w_sin[k])
        );
    end

    ths_coord #(.OUT_FRAC_BITS (OUT_FRAC_BITS)) u_coord_x (
        .i_clk    (i_clk),
        .i_radius (r_radius),
        .i_sin    (w_sin[0]),
        .i_cos    (w_sin[1]),
        .o_coord  (o_out.coord_x)
    );

    ths_coord #(.OUT_FRAC_BITS (OUT_FRAC_BITS)) u_coord_y (
        .i_clk    (i_clk),
        .i_radius (r_radius),
        .i_sin    (w_sin[2]),
        .i_cos    (w_sin[3]),
        .o_coord  (o_out.coord_y)
    );

    ths_coord #(.OUT_FRAC_BITS (OUT_FRAC_BITS)) u_coord_z (
        .i_clk    (i_clk),
        .i_radius (r_radius),
        .i_sin    (w_sin[4]),
        .i_cos    (w_sin[5]),
        .o_coord  (o_out.coord_z)
    );

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_vld[LATENCY-1];

endmodule

@@ test/triaxial_hexatorus_point_tb.sv @@
// ============================================================================
// triaxial_hexatorus_point_tb: self-checking bench for the hexatorus point
// Drives angle pairs through several radius settings and idle patterns, and
// compares every point with a fixed-point prediction computed in the bench.
// ============================================================================
`timescale 1ns / 100ps

module triaxial_hexatorus_point_tb;

    localparam int unsigned LATENCY     = 46;
    localparam longint      CYCLE_LIMIT = 400000;

    localparam longint unsigned TURN         = 64'd65536;
    localparam longint unsigned TURN_MASK    = TURN - 1;
    localparam longint unsigned HALF_TURN    = TURN >> 1;
    localparam longint unsigned QUARTER_TURN = TURN >> 2;
    localparam longint unsigned THIRD_TURN   = (TURN + 1) / 3;
    localparam longint unsigned PI_Q30_L     = 64'd3373259426;
    localparam longint unsigned ONE_Q30_L    = 64'd1 << 30;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    ths_pkg::t_in  i_in;
    logic          o_strobe;
    ths_pkg::t_out o_out;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [15:0]   i_cfg_data;

    triaxial_hexatorus_point dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_strobe(o_strobe), .o_out(o_out), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    ths_pkg::t_in  angle_queue[$];
    ths_pkg::t_out point_queue[$];
    logic [15:0]   radius_now;
    int            idle_pct;
    int            mismatches;
    longint        cycles;
    logic [15:0]   cfg_pending;
    logic          cfg_request;
    logic          cfg_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint signed sine_q15(longint unsigned a);
        logic            neg;
        longint unsigned x, x2, t, s, r;
        neg = 1'b0;
        a &= TURN_MASK;
        if (a >= HALF_TURN) begin
            neg = 1'b1;
            a -= HALF_TURN;
        end
        if (a > QUARTER_TURN) a = HALF_TURN - a;
        x = (a * PI_Q30_L + (HALF_TURN >> 1)) >> 15;
        x2 = (x * x) >> 30;
        t = ONE_Q30_L - x2 / 72;
        t = ONE_Q30_L - ((x2 * t) >> 30) / 42;
        t = ONE_Q30_L - ((x2 * t) >> 30) / 20;
        t = ONE_Q30_L - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        r = (s + (64'd1 << 14)) >> 15;
        if (r > 32767) r = 32767;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint signed cosine_q15(longint unsigned a);
        return sine_q15(a + QUARTER_TURN);
    endfunction

    function automatic logic [23:0] scaled_quotient(longint signed sn, longint signed cs);
        longint signed   num;
        longint unsigned den, mag, q;
        logic            neg;
        num = longint'(radius_now) * sn;
        den = longint'(46341) + cs;
        neg = num < 0;
        mag = longint'(neg ? -num : num) << 4;
        q = (2 * mag + den) / (2 * den);
        if (neg) return (q > 64'd8388608) ? ths_pkg::OUT_MIN : 24'(-longint'(q));
        return (q > 64'd8388607) ? ths_pkg::OUT_MAX : 24'(q);
    endfunction

    function automatic ths_pkg::t_out surface_point(ths_pkg::t_in a);
        longint unsigned u, v;
        ths_pkg::t_out   p;
        u = longint'(a.angle_u) & TURN_MASK;
        v = longint'(a.angle_v) & TURN_MASK;
        p.coord_x = scaled_quotient(sine_q15(u), cosine_q15(v));
        p.coord_y = scaled_quotient(sine_q15(u + THIRD_TURN), cosine_q15(v + THIRD_TURN));
        p.coord_z = scaled_quotient(cosine_q15(u + TURN - THIRD_TURN),
                                    cosine_q15(v + TURN - THIRD_TURN));
        return p;
    endfunction

    task automatic report_mismatch(string line);
        $display("mismatch %s", line);
        mismatches++;
    endtask

    // Driver: one transfer per edge with start high and busy low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                point_queue.push_back(surface_point(i_in));
            end
            if ((!start || !busy) && angle_queue.size() > 0 &&
                    $urandom_range(99, 0) >= idle_pct) begin
                start <= 1'b1;
                i_in  <= angle_queue.pop_front();
            end else if (!start || !busy) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_strobe) begin
            if (point_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected point %h", o_out));
            end else begin
                ths_pkg::t_out want;
                want = point_queue.pop_front();
                if (o_out.coord_x !== want.coord_x)
                    report_mismatch($sformatf("coord_x: got %0d expected %0d",
                                              o_out.coord_x, want.coord_x));
                if (o_out.coord_y !== want.coord_y)
                    report_mismatch($sformatf("coord_y: got %0d expected %0d",
                                              o_out.coord_y, want.coord_y));
                if (o_out.coord_z !== want.coord_z)
                    report_mismatch($sformatf("coord_z: got %0d expected %0d",
                                              o_out.coord_z, want.coord_z));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Register write channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
            cfg_done    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            i_cfg_valid <= 1'b0;
            radius_now  <= i_cfg_data;
            cfg_done    <= 1'b1;
        end else if (cfg_request && !i_cfg_valid && !cfg_done) begin
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= cfg_pending;
        end else if (!cfg_request) begin
            cfg_done <= 1'b0;
        end
    end

    task automatic drain();
        while (angle_queue.size() > 0 || start || point_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [15:0] r);
        cfg_pending = r;
        cfg_request = 1'b1;
        while (!cfg_done) @(posedge i_clk);
        cfg_request = 1'b0;
        while (cfg_done) @(posedge i_clk);
    endtask

    function automatic ths_pkg::t_in angle_pair(logic [15:0] u, logic [15:0] v);
        ths_pkg::t_in a;
        a.angle_u = u;
        a.angle_v = v;
        return a;
    endfunction

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++)
            angle_queue.push_back(angle_pair(16'($urandom), 16'($urandom)));
    endtask

    initial begin
        logic [15:0] radius_steps[5];
        int          idle_steps[4];
        radius_steps = '{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'h1234};
        idle_steps   = '{0, 76, 6, 0};
        mismatches  = 0;
        cycles      = 0;
        idle_pct    = 0;
        radius_now  = 16'd256;
        cfg_request = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Each radius, reset one first: angle extremes and quadrant points.
        foreach (radius_steps[k]) begin
            angle_queue.push_back(angle_pair(16'h8000, 16'h7FFF));
            angle_queue.push_back(angle_pair(16'h7FFF, 16'h8000));
            angle_queue.push_back(angle_pair(16'h0000, 16'h0000));
            angle_queue.push_back(angle_pair(16'hFFFF, 16'h0001));
            angle_queue.push_back(angle_pair(16'h4000, 16'h8000));
            angle_queue.push_back(angle_pair(16'hC000, 16'h8000));
            angle_queue.push_back(angle_pair(16'h5555, 16'h2AAB));
            angle_queue.push_back(angle_pair(16'hAAAB, 16'hD555));
            if (k == 0) begin
                angle_queue.push_back(angle_pair(16'h2000, 16'h6000));
                angle_queue.push_back(angle_pair(16'hE000, 16'hA000));
            end
            queue_random(k == 1 ? 300 : 100);
            for (int ph = 0; ph < 4; ph++) begin
                idle_pct = idle_steps[ph];
                queue_random(10);
                drain();
            end
            if (k < 4) write_radius(radius_steps[k + 1]);
        end
        drain();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ths_pkg.sv
rtl/ths_poly_cell.sv
rtl/ths_sine.sv
rtl/ths_div_cell.sv
rtl/ths_coord.sv
rtl/triaxial_hexatorus_point.sv
test/triaxial_hexatorus_point_tb.sv
